>>> rtl/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants for the page-organized OLED frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ofb_pkg;

  localparam int PAGES      = 8;
  localparam int COLUMNS    = 128;
  localparam int PAGE_W     = $clog2(PAGES);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ADDR_W     = PAGE_W + COL_W;
  localparam int DEPTH      = PAGES * COLUMNS;
  localparam int HEADER_LEN = 3;
  localparam int STREAM_LEN = HEADER_LEN + COLUMNS;
  localparam int POS_W      = $clog2(STREAM_LEN);
  localparam int ROWS       = PAGES * 8;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;

  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] x;
    logic [7:0] y;
    logic       dat;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } out_t;

  // Next refresh byte as seen from the stream sequencer
  typedef struct packed {
    logic [7:0]        cmd_byte;
    logic              is_data;
    logic              frame_end;
    logic [ADDR_W-1:0] addr;
  } refresh_info_t;

  // Buffer write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

`default_nettype wire

>>> rtl/oled_frame_buffer_refresh_top.sv
// ----------------------------------------------------------------------------
// oled_frame_buffer_refresh_top
// Page-organized monochrome frame buffer with SSD1306-style refresh stream.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-byte buffer, one byte per cycle, and
// holds in_stall high until the clear is done. After that it takes one
// transaction per cycle: a draw does a read-modify-write of one buffer byte
// (read, then merge and write back, with forwarding from the
// previous write), and a refresh transaction reads the buffer in the same
// slot and passes its byte through stage 1 into the output register. The
// input stalls only while a refresh result cannot move into the output
// register.
`default_nettype none

module oled_frame_buffer_refresh_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ofb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ofb_pkg::out_t      out_data
);

  // Clearing pass
  logic [ofb_pkg::ADDR_W:0] clr_cnt_r;
  logic                     clearing;

  assign clearing = !clr_cnt_r[ofb_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Accept stage
  ofb_pkg::refresh_info_t    info;
  logic                      in_accept;
  logic                      is_ref;
  logic                      draw_ok;
  logic [ofb_pkg::ADDR_W-1:0] draw_addr;
  logic                      rd_en;
  logic [ofb_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                rd_data;

  // Stage 1
  logic                      s1_vld_r;
  logic                      s1_ref_r;
  logic [ofb_pkg::ADDR_W-1:0] s1_addr_r;
  logic [7:0]                s1_cmd_r;
  logic                      s1_is_data_r;
  logic                      s1_end_r;
  logic [2:0]                s1_bit_r;
  logic                      s1_dat_r;
  logic                      s1_go;

  // Forwarding of the last write
  logic                      fwd_vld_r;
  logic [ofb_pkg::ADDR_W-1:0] fwd_addr_r;
  logic [7:0]                fwd_data_r;

  logic [7:0]                cur_byte;
  logic [7:0]                bit_mask;
  logic [7:0]                new_byte;
  ofb_pkg::wr_req_t          wr;

  logic                      out_valid_r;
  ofb_pkg::out_t             out_data_r;

  assign s1_go     = !s1_vld_r || !s1_ref_r || !out_valid_r || !out_stall;
  assign in_stall  = clearing || !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign is_ref    = (in_data.op == ofb_pkg::OP_REFRESH);
  assign draw_ok   = (in_data.x < 8'(ofb_pkg::COLUMNS)) && (in_data.y < 8'(ofb_pkg::ROWS));
  assign draw_addr = {in_data.y[ofb_pkg::PAGE_W+2:3], in_data.x[ofb_pkg::COL_W-1:0]};
  assign rd_en     = in_accept && (is_ref || draw_ok);
  assign rd_addr   = is_ref ? info.addr : draw_addr;

  ofb_refresh_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept && is_ref),
    .info    (info)
  );

  ofb_buf_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_go) begin
      s1_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_ref_r     <= is_ref;
      s1_addr_r    <= rd_addr;
      s1_cmd_r     <= info.cmd_byte;
      s1_is_data_r <= info.is_data;
      s1_end_r     <= info.frame_end;
      s1_bit_r     <= in_data.y[2:0];
      s1_dat_r     <= in_data.dat;
    end
  end

  // A read issued on the same edge as a write saw stale data
  assign cur_byte = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
  assign bit_mask = 8'(1) << s1_bit_r;
  assign new_byte = s1_dat_r ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);

  always_comb begin
    if (clearing) begin
      wr.en   = 1'b1;
      wr.addr = clr_cnt_r[ofb_pkg::ADDR_W-1:0];
      wr.data = 8'h00;
    end else begin
      wr.en   = s1_vld_r && !s1_ref_r;
      wr.addr = s1_addr_r;
      wr.data = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (s1_go) begin
      fwd_vld_r <= s1_vld_r && !s1_ref_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_vld_r && s1_ref_r && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_ref_r && s1_go) begin
      out_data_r.out_byte  <= s1_is_data_r ? cur_byte : s1_cmd_r;
      out_data_r.is_data   <= s1_is_data_r;
      out_data_r.frame_end <= s1_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/ofb_buf_ram.sv
// ----------------------------------------------------------------------------
// ofb_buf_ram
// Pixel buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_buf_ram (
  input  wire logic                      clk,
  input  wire ofb_pkg::wr_req_t          wr,
  input  wire logic                      rd_en,
  input  wire logic [ofb_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  logic [7:0] mem [ofb_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read returns the old contents on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ofb_refresh_seq.sv
// ----------------------------------------------------------------------------
// ofb_refresh_seq
// Page / position counters of the display stream: three commands, then
// one data byte per column, page after page.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_refresh_seq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   advance,
  output ofb_pkg::refresh_info_t      info
);

  logic [ofb_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [ofb_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [ofb_pkg::POS_W-1:0]  col_full;
  logic [ofb_pkg::COL_W-1:0]  col;

  assign col_full = pos_r - ofb_pkg::POS_W'(ofb_pkg::HEADER_LEN);
  assign col      = col_full[ofb_pkg::COL_W-1:0];

  always_comb begin
    info.addr      = {page_r, col};
    info.is_data   = 1'b0;
    info.frame_end = 1'b0;
    info.cmd_byte  = ofb_pkg::CMD_COL_LOW;
    if (pos_r == ofb_pkg::POS_W'(0)) begin
      info.cmd_byte = 8'(ofb_pkg::CMD_PAGE_BASE + 8'(page_r));
    end else if (pos_r == ofb_pkg::POS_W'(1)) begin
      info.cmd_byte = ofb_pkg::CMD_COL_HIGH;
    end else if (pos_r == ofb_pkg::POS_W'(2)) begin
      info.cmd_byte = ofb_pkg::CMD_COL_LOW;
    end else begin
      info.is_data   = 1'b1;
      info.frame_end = (col == ofb_pkg::COL_W'(ofb_pkg::COLUMNS - 1)) &&
                       (page_r == ofb_pkg::PAGE_W'(ofb_pkg::PAGES - 1));
    end
  end

  always_comb begin
    page_nxt = page_r;
    pos_nxt  = pos_r;
    if (advance) begin
      if (pos_r == ofb_pkg::POS_W'(ofb_pkg::STREAM_LEN - 1)) begin
        pos_nxt = '0;
        if (page_r == ofb_pkg::PAGE_W'(ofb_pkg::PAGES - 1)) begin
          page_nxt = '0;
        end else begin
          page_nxt = page_r + 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      pos_r  <= '0;
    end else begin
      page_r <= page_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ofb_checker.sv
// ----------------------------------------------------------------------------
// ofb_checker
// Port-level checks on the frame buffer's output stream and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire ofb_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ofb_pkg::out_t out_data
);

  // Held transaction must stay put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Stalled input transaction must stay put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // Buffer clear must block input right after reset
  a_clear_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.is_data)
    else $error("frame end on a command byte");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |->
      (out_data.out_byte[7:4] == ofb_pkg::CMD_PAGE_BASE[7:4]) ||
      (out_data.out_byte == ofb_pkg::CMD_COL_HIGH) ||
      (out_data.out_byte == ofb_pkg::CMD_COL_LOW))
    else $error("unexpected command byte");

endmodule

bind oled_frame_buffer_refresh_top ofb_checker u_ofb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> dv/tb_oled_frame_buffer_refresh_top.sv
// ----------------------------------------------------------------------------
// tb_oled_frame_buffer_refresh_top
// Self-checking bench for the page-organized frame buffer and refresh stream.
// A short table of directed transactions (corner pixels, off-screen draws,
// ignored fields, back-to-back draw and read of one byte) is followed by
// random pixel draws mixed with refresh requests, many of them aimed at the
// byte the stream is about to read. A shadow buffer predicts every refresh
// byte, and the output channel is checked in order under random stalls.
// ----------------------------------------------------------------------------

module tb_oled_frame_buffer_refresh_top;

  localparam int RAND_ITEMS   = 1250;
  localparam int DRAIN_CYCLES = 16;
  // timeout guard covering the clearing pass and all transactions with idling
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    ofb_pkg::in_t  item;
    logic          known;  // want holds a hand-written expectation
    ofb_pkg::out_t want;
  } dir_row_t;

  localparam ofb_pkg::out_t NO_WANT = '0;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // stream header after reset, then column 0 of the cleared buffer
    '{'{ofb_pkg::OP_REFRESH, 8'h00, 8'h00, 1'b0}, 1'b1, '{ofb_pkg::CMD_PAGE_BASE, 1'b0, 1'b0}},
    '{'{ofb_pkg::OP_REFRESH, 8'hFF, 8'hFF, 1'b1}, 1'b1, '{ofb_pkg::CMD_COL_HIGH, 1'b0, 1'b0}},
    '{'{ofb_pkg::OP_REFRESH, 8'h00, 8'h00, 1'b0}, 1'b1, '{ofb_pkg::CMD_COL_LOW, 1'b0, 1'b0}},
    '{'{ofb_pkg::OP_REFRESH, 8'hFF, 8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    // corners, then draws just off the screen
    '{'{ofb_pkg::OP_DRAW, 8'h00, 8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h7F, 8'h3F, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h80, 8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h00, 8'h40, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'hFF, 8'hFF, 1'b1}, 1'b0, NO_WANT},
    // draw immediately followed by the read of the same byte
    '{'{ofb_pkg::OP_DRAW, 8'h01, 8'h07, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_REFRESH, 8'h00, 8'h00, 1'b0}, 1'b0, NO_WANT},
    // set/clear/set of one byte back to back
    '{'{ofb_pkg::OP_DRAW, 8'h02, 8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h02, 8'h00, 1'b0}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h02, 8'h01, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h02, 8'h06, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_REFRESH, 8'h5A, 8'hA5, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h03, 8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_REFRESH, 8'h00, 8'h00, 1'b0}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h03, 8'h00, 1'b0}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h04, 8'h3F, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h04, 8'h07, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h04, 8'h07, 1'b0}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_REFRESH, 8'h00, 8'h00, 1'b0}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_DRAW, 8'h7F, 8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{ofb_pkg::OP_REFRESH, 8'hFF, 8'h00, 1'b1}, 1'b0, NO_WANT}
  };

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  ofb_pkg::in_t  in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  ofb_pkg::out_t out_data;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  oled_frame_buffer_refresh_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow of the frame buffer and the refresh sequencer
  logic [7:0]                 fb_shadow [ofb_pkg::DEPTH];
  logic [ofb_pkg::PAGE_W-1:0] scan_page = '0;
  int                         scan_pos  = 0;
  ofb_pkg::out_t              pending_bytes [$];

  int errors      = 0;
  int n_draws     = 0;
  int n_refresh   = 0;
  int n_frames    = 0;
  int n_checked   = 0;
  int phase       = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < ofb_pkg::DEPTH; i++) fb_shadow[i] = 8'h00;
  end

  task automatic frame_update(input ofb_pkg::in_t t, output logic has_byte,
                              output ofb_pkg::out_t b);
    int idx;
    int col;
    has_byte = 1'b0;
    b = '0;
    if (t.op == ofb_pkg::OP_DRAW) begin
      n_draws++;
      if (t.x < ofb_pkg::COLUMNS && t.y < ofb_pkg::ROWS) begin
        idx = int'(t.y >> 3) * ofb_pkg::COLUMNS + int'(t.x);
        fb_shadow[idx][t.y[2:0]] = t.dat;
      end
    end else begin
      has_byte = 1'b1;
      n_refresh++;
      if (scan_pos == 0) begin
        b.out_byte = ofb_pkg::CMD_PAGE_BASE + 8'(scan_page);
      end else if (scan_pos == 1) begin
        b.out_byte = ofb_pkg::CMD_COL_HIGH;
      end else if (scan_pos == 2) begin
        b.out_byte = ofb_pkg::CMD_COL_LOW;
      end else begin
        col = scan_pos - ofb_pkg::HEADER_LEN;
        b.out_byte = fb_shadow[int'(scan_page) * ofb_pkg::COLUMNS + col];
        b.is_data  = 1'b1;
        if (col == ofb_pkg::COLUMNS - 1 && int'(scan_page) == ofb_pkg::PAGES - 1) begin
          b.frame_end = 1'b1;
          n_frames++;
        end
      end
      if (scan_pos + 1 >= ofb_pkg::STREAM_LEN) begin
        scan_pos  = 0;
        scan_page = (int'(scan_page) + 1 >= ofb_pkg::PAGES) ? '0 : scan_page + 1'b1;
      end else begin
        scan_pos++;
      end
    end
  endtask

  task automatic send_transaction(input ofb_pkg::in_t t, input logic known,
                                  input ofb_pkg::out_t want);
    int            idle_pct;
    logic          has_byte;
    ofb_pkg::out_t b;
    idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_update(t, has_byte, b);
    if (has_byte) pending_bytes.push_back(known ? want : b);
  endtask

  // receiver: random stall and in-order compare
  always @(posedge clk) begin
    ofb_pkg::out_t exp_b;
    int            stall_pct;
    stall_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, actual %02h is_data=%0b frame_end=%0b",
                 $time, out_data.out_byte, out_data.is_data, out_data.frame_end);
      end else begin
        exp_b = pending_bytes.pop_front();
        n_checked++;
        if (out_data.out_byte !== exp_b.out_byte) begin
          errors++;
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, exp_b.out_byte, out_data.out_byte);
        end
        if (out_data.is_data !== exp_b.is_data) begin
          errors++;
          $display("%0t: is_data mismatch, expected %0b, actual %0b",
                   $time, exp_b.is_data, out_data.is_data);
        end
        if (out_data.frame_end !== exp_b.frame_end) begin
          errors++;
          $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                   $time, exp_b.frame_end, out_data.frame_end);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d refresh bytes outstanding", $time, pending_bytes.size());
      $display("** oled_frame_buffer_refresh_top: FAILED **");
      $finish;
    end
  end

  initial begin
    ofb_pkg::in_t t;
    int           sel;
    int           base;
    int           col;
    int           n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_transaction(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].want);

    // keep going past the item count until the stream has wrapped once
    for (n = 0; n < RAND_ITEMS || n_frames == 0; n++) begin
      phase = (n + DIR_ROWS < 430) ? 0 : (n + DIR_ROWS < 860) ? 1 : 2;
      t.x   = 8'($urandom);
      t.y   = 8'($urandom);
      t.dat = ($urandom_range(9) < 7);
      if ($urandom_range(99) < 85) begin
        t.op = ofb_pkg::OP_REFRESH;
      end else begin
        t.op = ofb_pkg::OP_DRAW;
        sel  = $urandom_range(9);
        if (sel >= 6) begin
          t.x = 8'($urandom_range(ofb_pkg::COLUMNS - 1));
          t.y = 8'($urandom_range(ofb_pkg::ROWS - 1));
        end else if (sel >= 2) begin
          // aim at the bytes the stream reads next
          base = (scan_pos < ofb_pkg::HEADER_LEN) ? 0 : scan_pos - ofb_pkg::HEADER_LEN;
          col  = base + $urandom_range(6);
          if (col > ofb_pkg::COLUMNS - 1) col = ofb_pkg::COLUMNS - 1;
          t.x = 8'(col);
          t.y = 8'(int'(scan_page) * 8 + $urandom_range(7));
        end
        // otherwise full-range noise, often off screen
      end
      send_transaction(t, 1'b0, NO_WANT);
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d pixel draws, %0d refresh requests.",
             n + DIR_ROWS, n_draws, n_refresh);
    $display("Checked %0d stream bytes over %0d full frames, %0d errors.",
             n_checked, n_frames, errors);
    if (errors == 0) begin
      $display("** oled_frame_buffer_refresh_top: PASSED **");
    end else begin
      $display("** oled_frame_buffer_refresh_top: FAILED **");
    end
    $finish;
  end

endmodule
